### sv/gcfs_pkg.sv
`default_nettype none
package gcfs_pkg;

   localparam int DEF_MAX_SAMPLES    = 256;
   localparam int DEF_MAX_FEATURES   = 64;
   localparam int DEF_MAX_DIRECTIONS = 16;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 4;

   localparam logic [8:0] RST_NUM_SAMPLES    = 9'd256;
   localparam logic [6:0] RST_NUM_FEATURES   = 7'd64;
   localparam logic [4:0] RST_NUM_DIRECTIONS = 5'd16;

   typedef enum logic [2:0] {
      ACT_FEAT_ENTRY  = 3'd0,
      ACT_FEAT_SPREAD = 3'd1,
      ACT_PROJ_ENTRY  = 3'd2,
      ACT_DIR_SPREAD  = 3'd3,
      ACT_RUN         = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      REG_NUM_SAMPLES    = 2'd0,
      REG_NUM_FEATURES   = 2'd1,
      REG_NUM_DIRECTIONS = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      SK_ZERO,
      SK_SAT,
      SK_DIV
   } score_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_FSTART,
      ST_FCHECK,
      ST_MAC,
      ST_DEN,
      ST_PRE,
      ST_DIV,
      ST_CMP,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

### sv/gcfs_ram.sv
`default_nettype none
module gcfs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

### sv/gcfs_div.sv
`default_nettype none
module gcfs_div #(
   parameter int MAG_W = 41
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [MAG_W-1:0] mag,
   input  wire logic [31:0]      den,
   output logic                  done,
   output logic      [31:0]      quotient
);

   localparam int NW = MAG_W + 16;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] q_ff, q_in;
   logic [31:0] den_ff, den_in;
   logic [NW-1:0] num;
   logic [32:0] trial;

   always_comb begin
      num     = {mag, 16'b0};
      trial   = {rem_ff[31:0], lo_ff[31]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      if (start) begin
         den_in = den;
         if (64'(mag) >= {16'b0, den, 16'b0}) begin
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            rem_in  = 33'(num >> 32);
            lo_in   = num[31:0];
            cnt_in  = 6'd32;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[30:0], 1'b0};
         end
         lo_in  = {lo_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule
`default_nettype wire

### sv/greedy_correlation_feature_select.sv
// Greedy correlation feature selection.
// req channel: one request per cycle while idle. tuser carries the action;
// loads of matrix entries and spreads give no result.
// A run request clears the used marks (one feature column at a time), then
// for each direction scores every unused feature column and returns one
// result on rsp, with tlast on the final direction.
// For each unused feature of a direction, a multiply-accumulate pass over
// the stores comes first, then the shared bit-serial divider where needed.
// req_tready is low from the run request until the last result is taken.
// A stalled rsp holds the result and the sequencer waits on it.
// Reset clears the sequencer and sets the register defaults; the stores
// hold nothing defined until loaded.
// CSR: APB, registers num_samples, num_features, num_directions at 0, 4, 8;
// write only while idle.
`default_nettype none
module greedy_correlation_feature_select #(
   parameter int MAX_SAMPLES    = gcfs_pkg::DEF_MAX_SAMPLES,
   parameter int MAX_FEATURES   = gcfs_pkg::DEF_MAX_FEATURES,
   parameter int MAX_DIRECTIONS = gcfs_pkg::DEF_MAX_DIRECTIONS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // row [7:0], col [13:8], value [29:14], zero [31:30]
   input  wire logic [gcfs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action [2:0]
   input  wire logic [2:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // selected_feature [6:0], best_score [38:7], zero [39]
   output logic      [gcfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // none_found [0]
   output logic      [0:0]                        rsp_tuser,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [gcfs_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic      [31:0]                       csr_prdata,
   output logic                                   csr_pready
);
   import gcfs_pkg::*;

   localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int DIR_W  = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1;
   localparam int RCNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int FCNT_W = $clog2(MAX_FEATURES + 1);
   localparam int DCNT_W = $clog2(MAX_DIRECTIONS + 1);
   localparam int FA_W   = $clog2(MAX_SAMPLES * MAX_FEATURES);
   localparam int PA_W   = $clog2(MAX_SAMPLES * MAX_DIRECTIONS);
   localparam int ACC_W  = 32 + RCNT_W;

   logic [8:0] num_samples_ff;
   logic [6:0] num_features_ff;
   logic [4:0] num_directions_ff;

   state_type state_ff, state_in;
   logic [RCNT_W-1:0] rows_ff, rows_in, r_ff, r_in;
   logic [FCNT_W-1:0] feats_ff, feats_in, f_ff, f_in;
   logic [DCNT_W-1:0] dirs_ff, dirs_in, d_ff, d_in;
   logic v1_ff, v1_in, v2_ff, v2_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] mag_ff, mag_in;
   logic [31:0] den_ff, den_in;
   score_kind_type kind_ff, kind_in;
   logic [31:0] score_ff, score_in, best_ff, best_in;
   logic [FEAT_W-1:0] pick_ff, pick_in;
   logic found_ff, found_in;

   logic signed [15:0] fx_q, pb_q, fs_q, ds_q;
   logic used_q;
   logic fe_we, fs_we, pe_we, ds_we, used_we, used_wd;
   logic [FA_W-1:0] fe_wa, fe_ra;
   logic [PA_W-1:0] pe_wa, pe_ra;
   logic [FEAT_W-1:0] used_wa;
   logic div_start, div_done;
   logic [31:0] div_q;
   logic [7:0] ld_row;
   logic [5:0] ld_col;
   logic [15:0] ld_val;
   logic [15:0] fs_abs, ds_abs;
   logic csr_we;

   assign ld_row = req_tdata[7:0];
   assign ld_col = req_tdata[13:8];
   assign ld_val = req_tdata[29:14];

   // configuration
   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_samples_ff    <= RST_NUM_SAMPLES;
         num_features_ff   <= RST_NUM_FEATURES;
         num_directions_ff <= RST_NUM_DIRECTIONS;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_paddr[3:2]))
            REG_NUM_SAMPLES:    num_samples_ff    <= csr_pwdata[8:0];
            REG_NUM_FEATURES:   num_features_ff   <= csr_pwdata[6:0];
            REG_NUM_DIRECTIONS: num_directions_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[3:2]))
         REG_NUM_SAMPLES:    csr_prdata = {23'b0, num_samples_ff};
         REG_NUM_FEATURES:   csr_prdata = {25'b0, num_features_ff};
         REG_NUM_DIRECTIONS: csr_prdata = {27'b0, num_directions_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // stores
   gcfs_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES * MAX_FEATURES)) u_feat (
      .clock(clock), .wr_en(fe_we), .wr_addr(fe_wa), .wr_data(ld_val),
      .rd_addr(fe_ra), .rd_data(fx_q)
   );
   gcfs_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES * MAX_DIRECTIONS)) u_proj (
      .clock(clock), .wr_en(pe_we), .wr_addr(pe_wa), .wr_data(ld_val),
      .rd_addr(pe_ra), .rd_data(pb_q)
   );
   gcfs_ram #(.WIDTH(16), .DEPTH(MAX_FEATURES)) u_fspread (
      .clock(clock), .wr_en(fs_we), .wr_addr(FEAT_W'(ld_col)), .wr_data(ld_val),
      .rd_addr(f_ff[FEAT_W-1:0]), .rd_data(fs_q)
   );
   gcfs_ram #(.WIDTH(16), .DEPTH(MAX_DIRECTIONS)) u_dspread (
      .clock(clock), .wr_en(ds_we), .wr_addr(DIR_W'(ld_col)), .wr_data(ld_val),
      .rd_addr(d_ff[DIR_W-1:0]), .rd_data(ds_q)
   );
   gcfs_ram #(.WIDTH(1), .DEPTH(MAX_FEATURES)) u_used (
      .clock(clock), .wr_en(used_we), .wr_addr(used_wa), .wr_data(used_wd),
      .rd_addr(f_ff[FEAT_W-1:0]), .rd_data(used_q)
   );

   gcfs_div #(.MAG_W(ACC_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .mag(mag_ff),
      .den(den_ff), .done(div_done), .quotient(div_q)
   );

   assign fe_wa = FA_W'(int'(ld_col) * MAX_SAMPLES + int'(ld_row));
   assign pe_wa = PA_W'(int'(ld_col) * MAX_SAMPLES + int'(ld_row));
   assign fe_ra = FA_W'(int'(f_ff) * MAX_SAMPLES + int'(r_ff));
   assign pe_ra = PA_W'(int'(d_ff) * MAX_SAMPLES + int'(r_ff));

   assign fs_abs = fs_q[15] ? 16'(-fs_q) : fs_q;
   assign ds_abs = ds_q[15] ? 16'(-ds_q) : ds_q;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {1'b0, best_ff, found_ff ? 7'(int'(pick_ff) + 1) : 7'd0};
   assign rsp_tuser  = ~found_ff;
   assign rsp_tlast  = (int'(d_ff) + 1 == int'(dirs_ff));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      rows_in   = rows_ff;
      feats_in  = feats_ff;
      dirs_in   = dirs_ff;
      r_in      = r_ff;
      f_in      = f_ff;
      d_in      = d_ff;
      v1_in     = 1'b0;
      v2_in     = v1_ff;
      prod_in   = $signed(fx_q) * $signed(pb_q);
      acc_in    = acc_ff;
      mag_in    = mag_ff;
      den_in    = den_ff;
      kind_in   = kind_ff;
      score_in  = score_ff;
      best_in   = best_ff;
      pick_in   = pick_ff;
      found_in  = found_ff;
      fe_we     = 1'b0;
      pe_we     = 1'b0;
      fs_we     = 1'b0;
      ds_we     = 1'b0;
      used_we   = 1'b0;
      used_wa   = f_ff[FEAT_W-1:0];
      used_wd   = 1'b0;
      div_start = 1'b0;
      if (v2_ff) begin
         acc_in = acc_ff + {{(ACC_W-32){prod_ff[31]}}, prod_ff};
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (action_type'(req_tuser))
                  ACT_FEAT_ENTRY:
                     fe_we = (int'(ld_row) < MAX_SAMPLES) && (int'(ld_col) < MAX_FEATURES);
                  ACT_FEAT_SPREAD:  fs_we = int'(ld_col) < MAX_FEATURES;
                  ACT_PROJ_ENTRY:
                     pe_we = (int'(ld_row) < MAX_SAMPLES) &&
                             (int'(ld_col) < MAX_DIRECTIONS);
                  ACT_DIR_SPREAD:   ds_we = int'(ld_col) < MAX_DIRECTIONS;
                  ACT_RUN: begin
                     rows_in  = (num_samples_ff == '0) ? RCNT_W'(1) :
                                (int'(num_samples_ff) > MAX_SAMPLES) ?
                                RCNT_W'(MAX_SAMPLES) : RCNT_W'(num_samples_ff);
                     feats_in = (num_features_ff == '0) ? FCNT_W'(1) :
                                (int'(num_features_ff) > MAX_FEATURES) ?
                                FCNT_W'(MAX_FEATURES) : FCNT_W'(num_features_ff);
                     dirs_in  = (num_directions_ff == '0) ? DCNT_W'(1) :
                                (int'(num_directions_ff) > MAX_DIRECTIONS) ?
                                DCNT_W'(MAX_DIRECTIONS) : DCNT_W'(num_directions_ff);
                     f_in     = '0;
                     d_in     = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            used_we = 1'b1;
            if (f_ff + FCNT_W'(1) == feats_ff) begin
               f_in     = '0;
               best_in  = '0;
               found_in = 1'b0;
               state_in = ST_FSTART;
            end else begin
               f_in = f_ff + FCNT_W'(1);
            end
         end
         ST_FSTART: state_in = ST_FCHECK;
         ST_FCHECK: begin
            acc_in = '0;
            r_in   = '0;
            if (used_q) begin
               state_in = ST_CMP;
               score_in = '0;
            end else begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (r_ff != rows_ff) begin
               v1_in = 1'b1;
               r_in  = r_ff + RCNT_W'(1);
            end else if (!v1_ff && !v2_ff) begin
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            mag_in = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
            den_in = fs_abs * ds_abs;
            if (acc_ff == '0 || (fs_q[15] && ds_q > 0) || (ds_q[15] && fs_q > 0)) begin
               kind_in = SK_ZERO;
            end else if (fs_q == '0 || ds_q == '0) begin
               kind_in = SK_SAT;
            end else begin
               kind_in = SK_DIV;
            end
            state_in = ST_PRE;
         end
         ST_PRE: begin
            case (kind_ff)
               SK_ZERO: begin
                  score_in = '0;
                  state_in = ST_CMP;
               end
               SK_SAT: begin
                  score_in = '1;
                  state_in = ST_CMP;
               end
               default: begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               score_in = div_q;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (score_ff > best_ff) begin
               best_in  = score_ff;
               pick_in  = f_ff[FEAT_W-1:0];
               found_in = 1'b1;
            end
            if (f_ff + FCNT_W'(1) == feats_ff) begin
               state_in = ST_EMIT;
            end else begin
               f_in     = f_ff + FCNT_W'(1);
               state_in = ST_FSTART;
            end
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               used_we  = found_ff;
               used_wa  = pick_ff;
               used_wd  = 1'b1;
               f_in     = '0;
               best_in  = '0;
               found_in = 1'b0;
               if (d_ff + DCNT_W'(1) == dirs_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  d_in     = d_ff + DCNT_W'(1);
                  state_in = ST_FSTART;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
      end
      rows_ff  <= rows_in;
      feats_ff <= feats_in;
      dirs_ff  <= dirs_in;
      r_ff     <= r_in;
      f_ff     <= f_in;
      d_ff     <= d_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      mag_ff   <= mag_in;
      den_ff   <= den_in;
      kind_ff  <= kind_in;
      score_ff <= score_in;
      best_ff  <= best_in;
      pick_ff  <= pick_in;
      found_ff <= found_in;
   end

endmodule
`default_nettype wire

### verif/greedy_correlation_feature_select_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module greedy_correlation_feature_select_tb;
   import gcfs_pkg::*;

   localparam int NSAMP = DEF_MAX_SAMPLES;
   localparam int NFEAT = DEF_MAX_FEATURES;
   localparam int NDIR  = DEF_MAX_DIRECTIONS;
   localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 12;

   typedef struct packed {
      logic [6:0]  feature;
      logic [31:0] score;
      logic        none;
      logic        last;
   } selection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   wire  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   wire  rsp_tvalid;
   logic rsp_tready = 1'b0;
   wire  [RSP_DATA_W-1:0] rsp_tdata;
   wire  [0:0] rsp_tuser;
   wire  rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire  csr_pready;

   greedy_correlation_feature_select dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] feat_mem [NFEAT][NSAMP];
   logic signed [15:0] proj_mem [NDIR][NSAMP];
   logic signed [15:0] feat_spread [NFEAT];
   logic signed [15:0] dir_spread [NDIR];
   bit feat_loaded [NFEAT][NSAMP];
   bit proj_loaded [NDIR][NSAMP];
   bit fspread_loaded [NFEAT];
   bit dspread_loaded [NDIR];
   logic [8:0] cfg_samples = RST_NUM_SAMPLES;
   logic [6:0] cfg_features = RST_NUM_FEATURES;
   logic [4:0] cfg_directions = RST_NUM_DIRECTIONS;

   selection_type expected_selections [$];
   int errors = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   int random_requests = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("greedy_correlation_feature_select_tb: FAIL");
         $finish;
      end
   end

   // result checker and receiver stalls
   always @(posedge clock) begin
      selection_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.feature = rsp_tdata[6:0];
            got.score = rsp_tdata[38:7];
            got.none = rsp_tuser[0];
            got.last = rsp_tlast;
            if (expected_selections.size() == 0) begin
               $display("%0t: result exp none act %h", $time, got);
               errors++;
            end else begin
               want = expected_selections.pop_front();
               if (got.feature !== want.feature)
                  $display("%0t: feature exp %0d act %0d", $time, want.feature, got.feature);
               if (got.score !== want.score)
                  $display("%0t: score exp %h act %h", $time, want.score, got.score);
               if (got.none !== want.none)
                  $display("%0t: none exp %b act %b", $time, want.none, got.none);
               if (got.last !== want.last)
                  $display("%0t: last exp %b act %b", $time, want.last, got.last);
               if (got !== want) errors++;
            end
         end
      end
   end

   function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [31:0] score_for(int f, int d, int rows);
      longint dot;
      longint unsigned mag, den, q;
      int fs, ds;
      dot = 0;
      for (int r = 0; r < rows; r++)
         dot += longint'(int'(feat_mem[f][r]) * int'(proj_mem[d][r]));
      if (dot == 0) return 32'd0;
      mag = (dot < 0) ? longint'(-dot) : longint'(dot);
      fs = int'(feat_spread[f]);
      ds = int'(dir_spread[d]);
      if ((fs < 0 && ds > 0) || (fs > 0 && ds < 0)) return 32'd0;
      if (fs == 0 || ds == 0) return 32'hFFFF_FFFF;
      den = longint'(fs < 0 ? -fs : fs) * longint'(ds < 0 ? -ds : ds);
      q = (mag << 16) / den;
      if (q > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return q[31:0];
   endfunction

   task automatic predict_selections();
      int rows, feats, dirs, pick;
      logic [31:0] best, s;
      bit used [NFEAT];
      bit found;
      selection_type sel;
      rows = clamp_count(int'(cfg_samples), NSAMP);
      feats = clamp_count(int'(cfg_features), NFEAT);
      dirs = clamp_count(int'(cfg_directions), NDIR);
      foreach (used[i]) used[i] = 0;
      for (int d = 0; d < dirs; d++) begin
         best = 0;
         pick = 0;
         found = 0;
         for (int f = 0; f < feats; f++) begin
            if (!used[f]) begin
               s = score_for(f, d, rows);
               if (s > best) begin
                  best = s;
                  pick = f;
                  found = 1;
               end
            end
         end
         if (found) used[pick] = 1;
         sel.feature = found ? 7'(pick + 1) : 7'd0;
         sel.score = found ? best : 32'd0;
         sel.none = !found;
         sel.last = (d + 1 == dirs);
         expected_selections.push_back(sel);
      end
   endtask

   task automatic send_request(logic [2:0] act, logic [7:0] row, logic [5:0] col,
                               logic [15:0] val);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {2'b00, val, col, row};
      do @(posedge clock); while (!req_tready);
      case (act)
         ACT_FEAT_ENTRY: begin
            feat_mem[col][row] = val;
            feat_loaded[col][row] = 1;
         end
         ACT_FEAT_SPREAD: begin
            feat_spread[col] = val;
            fspread_loaded[col] = 1;
         end
         ACT_PROJ_ENTRY: if (col < NDIR) begin
            proj_mem[col][row] = val;
            proj_loaded[col][row] = 1;
         end
         ACT_DIR_SPREAD: if (col < NDIR) begin
            dir_spread[col] = val;
            dspread_loaded[col] = 1;
         end
         ACT_RUN: predict_selections();
         default: ;
      endcase
   endtask

   task automatic release_request();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (expected_selections.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_NUM_SAMPLES: cfg_samples = val[8:0];
         REG_NUM_FEATURES: cfg_features = val[6:0];
         REG_NUM_DIRECTIONS: cfg_directions = val[4:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(int s, int f, int d);
      release_request();
      wait_idle();
      csr_write(REG_NUM_SAMPLES, s);
      csr_write(REG_NUM_FEATURES, f);
      csr_write(REG_NUM_DIRECTIONS, d);
   endtask

   function automatic logic [15:0] rand_entry();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_spread();
      case ($urandom_range(19))
         0: return 16'h0000;
         1: return 16'(-$signed($urandom_range(1, 8192)));
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom_range(256, 16384));
      endcase
   endfunction

   // loads every store entry that the next run will read and that is still unset
   task automatic load_missing();
      int rows, feats, dirs;
      rows = clamp_count(int'(cfg_samples), NSAMP);
      feats = clamp_count(int'(cfg_features), NFEAT);
      dirs = clamp_count(int'(cfg_directions), NDIR);
      for (int f = 0; f < feats; f++) begin
         for (int r = 0; r < rows; r++)
            if (!feat_loaded[f][r])
               send_request(ACT_FEAT_ENTRY, 8'(r), 6'(f), rand_entry());
         if (!fspread_loaded[f]) send_request(ACT_FEAT_SPREAD, 8'd0, 6'(f), rand_spread());
      end
      for (int d = 0; d < dirs; d++) begin
         for (int r = 0; r < rows; r++)
            if (!proj_loaded[d][r])
               send_request(ACT_PROJ_ENTRY, 8'(r), 6'(d), rand_entry());
         if (!dspread_loaded[d]) send_request(ACT_DIR_SPREAD, 8'd0, 6'(d), rand_spread());
      end
   endtask

   task automatic test_special_cases();
      logic [15:0] fcol [4][2];
      logic [15:0] pcol [3][2];
      logic [15:0] fsp [4];
      logic [15:0] dsp [3];
      configure(2, 4, 3);
      fcol = '{'{16'h0000, 16'h0000}, '{16'h7FFF, 16'h7FFF},
               '{16'd100, 16'd200}, '{16'h8000, 16'd5}};
      fsp = '{16'h1000, 16'hFFFF, 16'h0000, 16'hF000};
      pcol = '{'{16'h1000, 16'h1000}, '{16'hF000, 16'h1000}, '{16'h0000, 16'h0000}};
      dsp = '{16'h1000, 16'hF000, 16'h1000};
      for (int f = 0; f < 4; f++) begin
         for (int r = 0; r < 2; r++)
            send_request(ACT_FEAT_ENTRY, 8'(r), 6'(f), fcol[f][r]);
         send_request(ACT_FEAT_SPREAD, 8'd0, 6'(f), fsp[f]);
      end
      for (int d = 0; d < 3; d++) begin
         for (int r = 0; r < 2; r++)
            send_request(ACT_PROJ_ENTRY, 8'(r), 6'(d), pcol[d][r]);
         send_request(ACT_DIR_SPREAD, 8'd0, 6'(d), dsp[d]);
      end
      send_request(ACT_PROJ_ENTRY, 8'hFF, 6'h3F, 16'hFFFF);
      send_request(ACT_DIR_SPREAD, 8'd0, 6'd16, 16'h1234);
      send_request(ACT_RESERVED_FIRST, 8'hAA, 6'h15, 16'h5555);
      send_request(ACT_RESERVED_LAST, 8'h55, 6'h2A, 16'hAAAA);
      send_request(ACT_RUN, 8'd0, 6'd0, 16'd0);
      send_request(ACT_RUN, 8'hFF, 6'h3F, 16'hFFFF);
   endtask

   task automatic test_register_extremes();
      configure(0, 127, 31);
      load_missing();
      send_request(ACT_RUN, 8'd0, 6'd0, 16'd0);
      configure(3, 2, 0);
      load_missing();
      send_request(ACT_RUN, 8'd0, 6'd0, 16'd0);
      configure(1, 64, 16);
      send_request(ACT_RUN, 8'd0, 6'd0, 16'd0);
   endtask

   task automatic random_segment();
      int rows, feats, dirs, n;
      if ($urandom_range(1)) begin
         if ($urandom_range(9) == 0) configure($urandom_range(10, 16), $urandom_range(1, 2),
                                               1);
         else configure($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(0, 5));
      end
      rows = clamp_count(int'(cfg_samples), NSAMP);
      feats = clamp_count(int'(cfg_features), NFEAT);
      dirs = clamp_count(int'(cfg_directions), NDIR);
      n = $urandom_range(2, 6);
      for (int i = 0; i < n; i++) begin
         random_requests++;
         case ($urandom_range(9))
            0: send_request(3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST)),
                            8'($urandom), 6'($urandom), 16'($urandom));
            1: send_request($urandom_range(1) ? ACT_PROJ_ENTRY : ACT_DIR_SPREAD,
                            8'($urandom), 6'($urandom_range(NDIR, 63)), 16'($urandom));
            2: send_request(ACT_FEAT_ENTRY, 8'($urandom), 6'($urandom), rand_entry());
            3: send_request(ACT_FEAT_SPREAD, 8'd0, 6'($urandom_range(feats - 1)),
                            rand_spread());
            4: send_request(ACT_DIR_SPREAD, 8'($urandom), 6'($urandom_range(dirs - 1)),
                            rand_spread());
            5, 6: send_request(ACT_PROJ_ENTRY, 8'($urandom_range(rows - 1)),
                               6'($urandom_range(dirs - 1)), rand_entry());
            default: send_request(ACT_FEAT_ENTRY, 8'($urandom_range(rows - 1)),
                                  6'($urandom_range(feats - 1)), rand_entry());
         endcase
      end
      load_missing();
      random_requests++;
      send_request(ACT_RUN, 8'($urandom), 6'($urandom), 16'($urandom));
   endtask

   task automatic test_random(int idle_pct, int stall_pct, int quota);
      sender_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      quota += random_requests;
      while (random_requests < quota) random_segment();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_cases();
      test_register_extremes();
      test_random(0, 0, 15);
      test_random(63, 0, 15);
      test_random(0, 63, 15);
      test_random(30, 30, 15);
      release_request();
      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_selections.size() == 0) begin
         $display("greedy_correlation_feature_select_tb: PASS");
      end else begin
         $display("greedy_correlation_feature_select_tb: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
